/* hw/rtl/cce_pkg.sv */
package cce_pkg;

  // parser modes
  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_CR,
    MODE_ESC,
    MODE_LEAD,
    MODE_NUM,
    MODE_SPACE
  } parse_mode_e;

  // event kinds on the result stream
  typedef enum logic [3:0] {
    EV_CHAR,
    EV_NEWLINE,
    EV_FONT,
    EV_TAB,
    EV_NAKED,
    EV_UNKNOWN,
    EV_BADCSI,
    EV_OVERFLOW,
    EV_UNTERM
  } event_kind_e;

  localparam int unsigned ArgW    = 14;
  localparam int unsigned AccW    = 12;
  localparam int unsigned MaxEvts = 3;

  localparam logic [7:0] CH_ESC       = 8'h1B;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CSI       = 8'h5B;
  localparam logic [7:0] CH_SGR       = 8'h6D;
  localparam logic [7:0] CH_TAB_FINAL = 8'h5E;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_HT        = 8'h09;

  localparam logic signed [ArgW-1:0] FONT_BASE = 14'sd10;
  localparam logic [AccW-1:0]        ACC_MAX   = 12'd4095;

  // one result event
  typedef struct packed {
    event_kind_e             kind;
    logic signed [ArgW-1:0]  arg;
    logic [7:0]              chr;
  } event_t;

  // all events caused by one byte, in order
  typedef struct packed {
    logic [1:0]           cnt;
    event_t [MaxEvts-1:0] ev;
  } event_list_t;

endpackage

/* hw/rtl/cce_parse_core.sv */
module cce_parse_core import cce_pkg::*; #(
  parameter int unsigned MAX_ARG_LEN = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  byte_i,
  input  logic        eot_i,
  input  logic        advance_i,
  output event_list_t list_o
);

  localparam int unsigned LenW = $clog2(MAX_ARG_LEN + 1);

  parse_mode_e     mode_q, mode_d;
  logic [AccW-1:0] acc_q, acc_d;
  logic            neg_q, neg_d;
  logic            closed_q, closed_d;
  logic [LenW-1:0] len_q, len_d;

  logic                   is_space;
  logic                   is_digit;
  logic [15:0]            acc_next;
  logic signed [ArgW-1:0] arg_mag;
  logic signed [ArgW-1:0] arg_sgn;

  assign is_space = byte_i inside {CH_SPACE, [CH_HT:CH_CR]};
  assign is_digit = byte_i inside {[CH_ZERO:CH_NINE]};
  assign acc_next = {4'b0, acc_q} * 16'd10 + {12'b0, byte_i[3:0]};
  assign arg_mag  = {2'b0, acc_q};
  assign arg_sgn  = neg_q ? -arg_mag : arg_mag;

  // next state and event list for the byte in the input register
  always_comb begin
    logic       do_plain;
    logic [1:0] n;
    logic       clear;
    do_plain = 1'b0;
    clear    = 1'b0;
    n        = '0;
    list_o   = '0;
    mode_d   = mode_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    closed_d = closed_q;
    len_d    = len_q;

    case (mode_q)
      MODE_CR: begin
        mode_d = MODE_IDLE;
        if (byte_i == CH_LF) begin
          list_o.ev[n].kind = EV_NEWLINE;
          n = n + 2'd1;
        end else begin
          list_o.ev[n].kind = EV_NAKED;
          n = n + 2'd1;
          list_o.ev[n].kind = EV_NEWLINE;
          n = n + 2'd1;
          do_plain = 1'b1;
        end
      end
      MODE_ESC: begin
        if (byte_i == CH_CSI) begin
          clear  = 1'b1;
          mode_d = MODE_LEAD;
        end else begin
          list_o.ev[n].kind = EV_UNKNOWN;
          n = n + 2'd1;
          mode_d = MODE_IDLE;
        end
      end
      MODE_LEAD, MODE_NUM: begin
        if (len_q != '0 && byte_i == CH_SGR) begin
          list_o.ev[n].kind = EV_FONT;
          list_o.ev[n].arg  = arg_sgn - FONT_BASE;
          n = n + 2'd1;
          mode_d = MODE_IDLE;
          clear  = 1'b1;
        end else if (len_q != '0 && byte_i == CH_SPACE) begin
          mode_d = MODE_SPACE;
        end else begin
          // argument byte
          if (!closed_q) begin
            if (mode_q == MODE_LEAD && is_space) begin
              mode_d = MODE_LEAD;
            end else if (mode_q == MODE_LEAD && byte_i == CH_MINUS) begin
              mode_d = MODE_NUM;
              neg_d  = 1'b1;
            end else if (mode_q == MODE_LEAD && byte_i == CH_PLUS) begin
              mode_d = MODE_NUM;
            end else begin
              mode_d = MODE_NUM;
              if (is_digit) begin
                acc_d = (acc_next > {4'b0, ACC_MAX}) ? ACC_MAX : acc_next[AccW-1:0];
              end else begin
                closed_d = 1'b1;
              end
            end
          end
          len_d = len_q + LenW'(1);
          if (len_d >= LenW'(MAX_ARG_LEN)) begin
            list_o.ev[n].kind = EV_OVERFLOW;
            n = n + 2'd1;
            mode_d = MODE_IDLE;
            clear  = 1'b1;
          end
        end
      end
      MODE_SPACE: begin
        if (byte_i == CH_TAB_FINAL) begin
          list_o.ev[n].kind = EV_TAB;
          list_o.ev[n].arg  = arg_sgn;
        end else begin
          list_o.ev[n].kind = EV_BADCSI;
        end
        n = n + 2'd1;
        mode_d = MODE_IDLE;
        clear  = 1'b1;
      end
      default: begin
        mode_d   = MODE_IDLE;
        do_plain = 1'b1;
      end
    endcase

    // ordinary byte handling, also after a naked cr
    if (do_plain) begin
      if (byte_i == CH_ESC) begin
        mode_d = MODE_ESC;
      end else if (byte_i == CH_CR) begin
        mode_d = MODE_CR;
      end else begin
        list_o.ev[n].kind = EV_CHAR;
        list_o.ev[n].chr  = byte_i;
        n = n + 2'd1;
      end
    end

    // end of the content portion
    if (eot_i) begin
      if (mode_d != MODE_IDLE) begin
        list_o.ev[n].kind = EV_UNTERM;
        n = n + 2'd1;
      end
      mode_d = MODE_IDLE;
      clear  = 1'b1;
    end

    if (clear) begin
      acc_d    = '0;
      neg_d    = 1'b0;
      closed_d = 1'b0;
      len_d    = '0;
    end
    list_o.cnt = n;
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      acc_q    <= '0;
      neg_q    <= 1'b0;
      closed_q <= 1'b0;
      len_q    <= '0;
    end else if (advance_i) begin
      mode_q   <= mode_d;
      acc_q    <= acc_d;
      neg_q    <= neg_d;
      closed_q <= closed_d;
      len_q    <= len_d;
    end
  end

endmodule

/* hw/rtl/cce_result_buf.sv */
module cce_result_buf import cce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  event_list_t list_i,
  output logic        can_load_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output event_t      head_o,
  output logic        last_o
);

  event_t [MaxEvts-1:0] pend_q, pend_d;
  logic [1:0]           cnt_q, cnt_d;
  logic                 pop;

  assign m_valid_o  = (cnt_q != 2'd0);
  assign pop        = m_valid_o && m_ready_i;
  assign can_load_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_ready_i);
  assign head_o     = pend_q[0];
  assign last_o     = (cnt_q == 2'd1);

  // drain one event per transfer, refill when empty or when the last event is taken
  always_comb begin
    pend_d = pend_q;
    cnt_d  = cnt_q;
    if (pop) begin
      pend_d[0] = pend_q[1];
      pend_d[1] = pend_q[2];
      cnt_d     = cnt_q - 2'd1;
    end
    if (load_i) begin
      pend_d = list_i.ev;
      cnt_d  = list_i.cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

endmodule

/* hw/rtl/char_content_escape_parser.sv */
// path: a byte waits in the input register until the result buffer can load its events
// throughput: one byte per cycle while each byte yields at most one event and the output
//   takes each event; a byte with more events holds the input until all but its last are taken
// reset: asynchronous active low, parser idle with the argument cleared, no events pending
module char_content_escape_parser import cce_pkg::*; #(
  parameter int unsigned MAX_ARG_LEN = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] text_byte
  input  logic        s_axis_tlast_i,   // end_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [13:0] arg_value, [21:14] char_out, [23:22] zero
  output logic [3:0]  m_axis_tuser_o,   // [3:0] event_kind
  output logic        m_axis_tlast_o    // last_event
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_eot_q;
  logic        accept;
  logic        consume;
  logic        can_load;
  event_list_t list;
  event_t      head;

  assign consume         = in_valid_q && can_load;
  assign s_axis_tready_o = !in_valid_q || consume;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (consume) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= s_axis_tdata_i;
      in_eot_q  <= s_axis_tlast_i;
    end
  end

  cce_parse_core #(
    .MAX_ARG_LEN(MAX_ARG_LEN)
  ) u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (in_byte_q),
    .eot_i    (in_eot_q),
    .advance_i(consume),
    .list_o   (list)
  );

  cce_result_buf u_result (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (consume),
    .list_i    (list),
    .can_load_o(can_load),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .head_o    (head),
    .last_o    (m_axis_tlast_o)
  );

  // output packing
  assign m_axis_tdata_o = {2'b00, head.chr, head.arg};
  assign m_axis_tuser_o = head.kind;

  // a held byte stays put until it is parsed
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !consume |=> in_valid_q && $stable(in_byte_q) && $stable(in_eot_q))
    else $error("input register changed while waiting");

  // only character events carry a character
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != EV_CHAR |-> m_axis_tdata_o[21:14] == 8'h00)
    else $error("character set on non-character event");

  // only font and tab events carry an argument
  a_arg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o != EV_FONT && m_axis_tuser_o != EV_TAB
    |-> m_axis_tdata_o[13:0] == 14'h0000)
    else $error("argument set on event without one");

  // an unterminated report always closes its byte
  a_unterm_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == EV_UNTERM |-> m_axis_tlast_o)
    else $error("unterminated event not last");

endmodule

/* verif/tb_char_content_escape_parser.sv */
`timescale 1ns / 1ps

module tb_char_content_escape_parser;
  import cce_pkg::*;

  localparam int unsigned ArgLenMax   = 16;
  localparam int unsigned PhaseBytes  = 130;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned NumCats     = 10;

  // sequence categories for the random part
  typedef enum int {
    SEQ_PLAIN,
    SEQ_CRLF,
    SEQ_NAKED_CR,
    SEQ_FONT,
    SEQ_TAB,
    SEQ_BADCSI,
    SEQ_UNKNOWN,
    SEQ_OVERFLOW,
    SEQ_FONT_SAT,
    SEQ_NOISE
  } seq_cat_e;

  typedef struct packed {
    event_kind_e             kind;
    logic signed [ArgW-1:0]  arg;
    logic [7:0]              chr;
    logic                    last;
  } text_event_t;

  typedef struct {
    logic [7:0]              b;
    logic                    eot;
    bit                      fixed;
    event_kind_e             kind;
    logic signed [ArgW-1:0]  arg;
    logic [7:0]              chr;
  } text_row_t;

  logic        clk_i;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = '0;
  logic        s_tlast  = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [23:0] m_axis_tdata_o;
  logic [3:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  char_content_escape_parser #(
    .MAX_ARG_LEN(ArgLenMax)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),   // [7:0] text_byte
    .s_axis_tlast_i  (s_tlast),   // end_of_text
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [13:0] arg_value, [21:14] char_out, [23:22] zero
    .m_axis_tuser_o  (m_axis_tuser_o),   // [3:0] event_kind
    .m_axis_tlast_o  (m_axis_tlast_o)    // last_event
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned errors        = 0;
  int unsigned bytes_sent    = 0;
  int unsigned events_seen   = 0;
  int unsigned seq_count     = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned kind_seen [9];

  text_event_t expected_events [$];
  text_event_t byte_events [$];
  logic [7:0]  byte_run [$];

  // parser state as predicted
  parse_mode_e     pmode;
  logic [AccW-1:0] acc;
  logic            neg;
  logic            closed;
  int unsigned     alen;

  // directed stimulus: fixed rows carry an expectation typed in by hand
  text_row_t directed_rows [27] = '{
    '{8'h41, 1'b0, 1'b1, EV_CHAR, 14'sd0, 8'h41},
    '{8'h00, 1'b0, 1'b1, EV_CHAR, 14'sd0, 8'h00},
    '{8'hFF, 1'b1, 1'b1, EV_CHAR, 14'sd0, 8'hFF},
    '{CH_CR, 1'b0, 1'b0, EV_CHAR, 14'sd0, 8'h00},
    '{CH_LF, 1'b0, 1'b1, EV_NEWLINE, 14'sd0, 8'h00},
    // naked cr followed by another cr, then a letter
    '{CH_CR, 1'b0, 1'b0, EV_CHAR, 14'sd0, 8'h00},
    '{CH_CR, 1'b0, 1'b0, EV_CHAR, 14'sd0, 8'h00},
    '{8'h42, 1'b0, 1'b0, EV_CHAR, 14'sd0, 8'h00},
    '{CH_ESC, 1'b0, 1'b0, EV_CHAR, 14'sd0, 8'h00},
    '{8'h78, 1'b0, 1'b1, EV_UNKNOWN, 14'sd0, 8'h00},
    // font select with a negative argument
    '{CH_ESC, 1'b0, 1'b0, EV_CHAR, 14'sd0, 8'h00},
    '{CH_CSI, 1'b0, 1'b0, EV_CHAR, 14'sd0, 8'h00},
    '{CH_MINUS, 1'b0, 1'b0, EV_CHAR, 14'sd0, 8'h00},
    '{8'h37, 1'b0, 1'b0, EV_CHAR, 14'sd0, 8'h00},
    '{CH_SGR, 1'b0, 1'b0, EV_CHAR, 14'sd0, 8'h00},
    // tab
    '{CH_ESC, 1'b0, 1'b0, EV_CHAR, 14'sd0, 8'h00},
    '{CH_CSI, 1'b0, 1'b0, EV_CHAR, 14'sd0, 8'h00},
    '{8'h39, 1'b0, 1'b0, EV_CHAR, 14'sd0, 8'h00},
    '{CH_SPACE, 1'b0, 1'b0, EV_CHAR, 14'sd0, 8'h00},
    '{CH_TAB_FINAL, 1'b0, 1'b0, EV_CHAR, 14'sd0, 8'h00},
    // space not followed by the tab final
    '{CH_ESC, 1'b0, 1'b0, EV_CHAR, 14'sd0, 8'h00},
    '{CH_CSI, 1'b0, 1'b0, EV_CHAR, 14'sd0, 8'h00},
    '{8'h34, 1'b0, 1'b0, EV_CHAR, 14'sd0, 8'h00},
    '{CH_SPACE, 1'b0, 1'b0, EV_CHAR, 14'sd0, 8'h00},
    '{8'h3F, 1'b0, 1'b1, EV_BADCSI, 14'sd0, 8'h00},
    // sequences cut off by end of text
    '{CH_ESC, 1'b1, 1'b1, EV_UNTERM, 14'sd0, 8'h00},
    '{CH_CR, 1'b1, 1'b1, EV_UNTERM, 14'sd0, 8'h00}
  };

  // ---------------------------------------------------------------- predictor

  function automatic void add_event(event_kind_e k, logic signed [ArgW-1:0] a,
                                    logic [7:0] c);
    text_event_t e;
    e.kind = k;
    e.arg  = a;
    e.chr  = c;
    e.last = 1'b0;
    byte_events.push_back(e);
  endfunction

  function automatic void reset_arg();
    acc    = '0;
    neg    = 1'b0;
    closed = 1'b0;
    alen   = 0;
  endfunction

  function automatic logic signed [ArgW-1:0] arg_with_sign();
    logic signed [ArgW-1:0] mag;
    mag = $signed({2'b00, acc});
    return neg ? -mag : mag;
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_HT && b <= CH_CR);
  endfunction

  // one argument byte into the decimal value
  function automatic void collect_digit(logic [7:0] b);
    int unsigned v;
    if (closed) return;
    if (pmode == MODE_LEAD) begin
      if (is_blank(b)) return;
      pmode = MODE_NUM;
      if (b == CH_MINUS) begin
        neg = 1'b1;
        return;
      end
      if (b == CH_PLUS) return;
    end
    if (b >= CH_ZERO && b <= CH_NINE) begin
      v = acc;
      v = v * 10 + (b - CH_ZERO);
      acc = (v > ACC_MAX) ? ACC_MAX : v[AccW-1:0];
    end else begin
      closed = 1'b1;
    end
  endfunction

  function automatic void fresh_byte(logic [7:0] b);
    if (b == CH_ESC) pmode = MODE_ESC;
    else if (b == CH_CR) pmode = MODE_CR;
    else add_event(EV_CHAR, '0, b);
  endfunction

  // events caused by one text byte, left in byte_events
  function automatic void predict_text_byte(logic [7:0] b, logic eot);
    byte_events.delete();
    case (pmode)
      MODE_CR: begin
        pmode = MODE_IDLE;
        if (b == CH_LF) begin
          add_event(EV_NEWLINE, '0, '0);
        end else begin
          add_event(EV_NAKED, '0, '0);
          add_event(EV_NEWLINE, '0, '0);
          fresh_byte(b);
        end
      end
      MODE_ESC: begin
        if (b == CH_CSI) begin
          reset_arg();
          pmode = MODE_LEAD;
        end else begin
          add_event(EV_UNKNOWN, '0, '0);
          pmode = MODE_IDLE;
        end
      end
      MODE_LEAD, MODE_NUM: begin
        if (alen > 0 && b == CH_SGR) begin
          add_event(EV_FONT, arg_with_sign() - FONT_BASE, '0);
          pmode = MODE_IDLE;
          reset_arg();
        end else if (alen > 0 && b == CH_SPACE) begin
          pmode = MODE_SPACE;
        end else begin
          collect_digit(b);
          alen++;
          if (alen >= ArgLenMax) begin
            add_event(EV_OVERFLOW, '0, '0);
            pmode = MODE_IDLE;
            reset_arg();
          end
        end
      end
      MODE_SPACE: begin
        if (b == CH_TAB_FINAL) add_event(EV_TAB, arg_with_sign(), '0);
        else add_event(EV_BADCSI, '0, '0);
        pmode = MODE_IDLE;
        reset_arg();
      end
      default: begin
        pmode = MODE_IDLE;
        fresh_byte(b);
      end
    endcase
    if (eot) begin
      if (pmode != MODE_IDLE) add_event(EV_UNTERM, '0, '0);
      pmode = MODE_IDLE;
      reset_arg();
    end
    if (byte_events.size() > 0) byte_events[$].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- stimulus

  // drive one byte and wait for its transfer, then predict its events
  task automatic transfer_byte(logic [7:0] b, logic eot);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eot;
    do @(posedge clk_i); while (!s_axis_tready_o);
    bytes_sent++;
    predict_text_byte(b, eot);
  endtask

  function automatic logic [7:0] pick_byte_not(logic [7:0] x, logic [7:0] y);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == x || b == y);
    return b;
  endfunction

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // argument text: whitespace, optional sign, digits, sometimes trailing junk
  function automatic void add_argument(bit long_num);
    int unsigned n_ws;
    int unsigned n_dig;
    int unsigned sgn;
    n_ws  = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
    sgn   = $urandom_range(0, 2);
    n_dig = long_num ? $urandom_range(5, 8) : $urandom_range(0, 4);
    if (n_ws > 0 && $urandom_range(0, 1) == 1) begin
      byte_run.push_back(CH_SPACE);
      n_ws--;
    end
    repeat (n_ws) byte_run.push_back(CH_HT + 8'($urandom_range(0, 4)));
    if (sgn == 1) byte_run.push_back(CH_MINUS);
    else if (sgn == 2) byte_run.push_back(CH_PLUS);
    repeat (n_dig) byte_run.push_back(pick_digit());
    if ($urandom_range(0, 4) == 0) begin
      byte_run.push_back(pick_byte_not(CH_SGR, CH_SPACE));
      repeat ($urandom_range(0, 2)) byte_run.push_back(pick_digit());
    end
    // an argument must have at least one byte before its terminator
    if (byte_run[$] == CH_CSI) byte_run.push_back(pick_digit());
  endfunction

  function automatic seq_cat_e pick_category();
    int unsigned r;
    if (seq_count < NumCats) return seq_cat_e'(seq_count);
    r = $urandom_range(0, 99);
    if (r < 10) return SEQ_NOISE;
    if (r < 30) return SEQ_PLAIN;
    if (r < 38) return SEQ_CRLF;
    if (r < 44) return SEQ_NAKED_CR;
    if (r < 58) return SEQ_FONT;
    if (r < 68) return SEQ_TAB;
    if (r < 74) return SEQ_BADCSI;
    if (r < 80) return SEQ_UNKNOWN;
    if (r < 85) return SEQ_OVERFLOW;
    if (r < 91) return SEQ_FONT_SAT;
    return SEQ_PLAIN;
  endfunction

  // build one sequence of the given category and send it
  task automatic send_sequence(seq_cat_e cat);
    logic eot;
    byte_run.delete();
    case (cat)
      SEQ_PLAIN:
        repeat ($urandom_range(1, 4)) byte_run.push_back(pick_byte_not(CH_ESC, CH_CR));
      SEQ_CRLF: begin
        byte_run.push_back(CH_CR);
        byte_run.push_back(CH_LF);
      end
      SEQ_NAKED_CR: begin
        byte_run.push_back(CH_CR);
        byte_run.push_back(pick_byte_not(CH_LF, CH_LF));
      end
      SEQ_FONT, SEQ_FONT_SAT: begin
        byte_run.push_back(CH_ESC);
        byte_run.push_back(CH_CSI);
        add_argument(cat == SEQ_FONT_SAT);
        byte_run.push_back(CH_SGR);
      end
      SEQ_TAB, SEQ_BADCSI: begin
        byte_run.push_back(CH_ESC);
        byte_run.push_back(CH_CSI);
        add_argument($urandom_range(0, 5) == 0);
        byte_run.push_back(CH_SPACE);
        if (cat == SEQ_TAB) byte_run.push_back(CH_TAB_FINAL);
        else byte_run.push_back(pick_byte_not(CH_TAB_FINAL, CH_TAB_FINAL));
      end
      SEQ_UNKNOWN: begin
        byte_run.push_back(CH_ESC);
        byte_run.push_back(pick_byte_not(CH_CSI, CH_CSI));
      end
      SEQ_OVERFLOW: begin
        byte_run.push_back(CH_ESC);
        byte_run.push_back(CH_CSI);
        byte_run.push_back(8'($urandom_range(0, 255)));
        repeat (ArgLenMax - 1) begin
          if ($urandom_range(0, 1) == 1) byte_run.push_back(pick_digit());
          else byte_run.push_back(pick_byte_not(CH_SGR, CH_SPACE));
        end
      end
      default:
        repeat ($urandom_range(1, 3)) byte_run.push_back(8'($urandom_range(0, 255)));
    endcase
    seq_count++;
    foreach (byte_run[i]) begin
      // end of text mostly at sequence ends, sometimes cutting one off
      if (i == byte_run.size() - 1) eot = ($urandom_range(0, 7) == 0);
      else eot = ($urandom_range(0, 39) == 0);
      transfer_byte(byte_run[i], eot);
      foreach (byte_events[k]) expected_events.push_back(byte_events[k]);
    end
  endtask

  // ---------------------------------------------------------------- checking

  function automatic void check_event();
    text_event_t want;
    logic signed [ArgW-1:0] got_arg;
    logic [7:0] got_chr;
    got_arg = m_axis_tdata_o[13:0];
    got_chr = m_axis_tdata_o[21:14];
    events_seen++;
    if (m_axis_tuser_o < 4'd9) kind_seen[m_axis_tuser_o]++;
    if (expected_events.size() == 0) begin
      $error("event_kind: no event expected, got %0d", m_axis_tuser_o);
      errors++;
      return;
    end
    want = expected_events.pop_front();
    if (m_axis_tuser_o !== want.kind) begin
      $error("event_kind: expected %0d, got %0d", want.kind, m_axis_tuser_o);
      errors++;
    end
    if (got_arg !== want.arg) begin
      $error("arg_value: expected %0d, got %0d", want.arg, got_arg);
      errors++;
    end
    if (got_chr !== want.chr) begin
      $error("char_out: expected 0x%02h, got 0x%02h", want.chr, got_chr);
      errors++;
    end
    if (m_axis_tlast_o !== want.last) begin
      $error("last_event: expected %0b, got %0b", want.last, m_axis_tlast_o);
      errors++;
    end
    if (m_axis_tdata_o[23:22] !== 2'b00) begin
      $error("tdata padding: expected 0, got %0b", m_axis_tdata_o[23:22]);
      errors++;
    end
  endfunction

  // result side: check each transfer, stall at random
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_tready) check_event();
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- main

  int unsigned phase_send_pct [3] = '{22, 64, 0};
  int unsigned phase_recv_pct [3] = '{64, 22, 0};

  initial begin
    int unsigned start_count;
    pmode = MODE_IDLE;
    reset_arg();
    send_idle_pct = phase_send_pct[0];
    recv_idle_pct = phase_recv_pct[0];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    foreach (directed_rows[i]) begin
      transfer_byte(directed_rows[i].b, directed_rows[i].eot);
      if (directed_rows[i].fixed) begin
        expected_events.push_back('{directed_rows[i].kind, directed_rows[i].arg,
                                    directed_rows[i].chr, 1'b1});
      end else begin
        foreach (byte_events[k]) expected_events.push_back(byte_events[k]);
      end
    end

    // random part in three handshake phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = phase_send_pct[ph];
      recv_idle_pct = phase_recv_pct[ph];
      start_count = bytes_sent;
      while (bytes_sent - start_count < PhaseBytes) send_sequence(pick_category());
    end
    s_tvalid <= 1'b0;

    // drain
    while (expected_events.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d text bytes in %0d sequences, checked %0d events", bytes_sent,
             seq_count, events_seen);
    $display("font %0d, tab %0d, naked cr %0d, bad csi %0d, overflow %0d, cut off %0d",
             kind_seen[EV_FONT], kind_seen[EV_TAB], kind_seen[EV_NAKED],
             kind_seen[EV_BADCSI], kind_seen[EV_OVERFLOW], kind_seen[EV_UNTERM]);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
